// ----- rtl/core/cover_drive_sequencer_core_assert.svh -----
// Assertion macros used by the checker file of the cover drive sequencer.
`ifndef COVER_DRIVE_SEQUENCER_CORE_ASSERT_SVH
`define COVER_DRIVE_SEQUENCER_CORE_ASSERT_SVH

// Check a same-cycle implication, disabled while reset is low.
`define CDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, disabled while reset is low.
`define CDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check an implication in the next cycle, also across reset.
`define CDS_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cds_pkg.sv -----
// Package of the cover drive sequencer: codes, constants and payload types.
package cds_pkg;

    // Operation of the cover, also used for the last direction moved
    typedef enum logic [1:0] {
        OP_IDLE    = 2'd0,
        OP_OPENING = 2'd1,
        OP_CLOSING = 2'd2
    } t_op;

    // Drive trigger fired in a step
    typedef enum logic [1:0] {
        TRIG_NONE  = 2'd0,
        TRIG_STOP  = 2'd1,
        TRIG_OPEN  = 2'd2,
        TRIG_CLOSE = 2'd3
    } t_trig;

    // Request action codes
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_STOP   = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_GOTO   = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_RUN    = 2'd0;
    localparam logic [1:0] CFG_DISENGAGE  = 2'd1;
    localparam logic [1:0] CFG_PUB_PERIOD = 2'd2;

    // Configuration reset values
    localparam logic [31:0] MAX_RUN_RESET    = 32'hFFFF_FFFF;
    localparam logic [31:0] DISENGAGE_RESET  = 32'd0;
    localparam logic [15:0] PUB_PERIOD_RESET = 16'd1000;

    // Positions in thousandths
    localparam logic [9:0] POS_OPEN      = 10'd1000;
    localparam logic [9:0] POS_CLOSED    = 10'd0;
    localparam logic [9:0] POS_RESET     = 10'd500;
    localparam logic [9:0] POS_TOLERANCE = 10'd10;

    // Input request payload
    typedef struct packed {
        logic [1:0] action;
        logic [9:0] sensor_position;
        logic [9:0] requested_position;
    } t_cds_in;

    // Result payload
    typedef struct packed {
        logic [1:0] drive_command;
        logic [1:0] operation;
        logic [9:0] reported_position;
        logic       publish;
    } t_cds_out;

    // Configuration registers as seen by the step logic
    typedef struct packed {
        logic [31:0] max_run_ms;
        logic [31:0] disengage_ms;
        logic [15:0] publish_period_ms;
    } t_cds_cfg;

    // Sequencer state
    typedef struct packed {
        t_op         op;
        t_op         last_dir;
        logic [9:0]  target;
        logic [9:0]  position;
        logic        disengaging;
        logic        disengaged;
        logic [31:0] run_timer;
        logic [31:0] dis_timer;
        logic [15:0] pub_timer;
    } t_cds_state;

endpackage

// ----- rtl/core/cds_in_stage.sv -----
// Input register stage of the cover drive sequencer.
module cds_in_stage
    import cds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_cds_in i_in,
    input  logic    i_advance,
    output logic    o_valid,
    output t_cds_in o_req
);

    logic    r_valid;
    t_cds_in r_req;

    // Hold the request while the result stage cannot advance
    assign o_in_stall = r_valid && !i_advance;

    // Capture a new request whenever the stage is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_req <= i_in;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ----- rtl/core/cds_step.sv -----
// Combinational step logic: next state and result for one request.
module cds_step
    import cds_pkg::*;
(
    input  t_cds_in    i_req,
    input  t_cds_state i_state,
    input  t_cds_cfg   i_cfg,
    output t_cds_state o_state,
    output t_cds_out   o_result
);

    typedef struct packed {
        t_cds_state st;
        t_trig      drive;
        logic       pub;
    } t_work;

    // Start a new direction; nothing happens if it is the current one
    function automatic t_work f_begin(t_work w, t_op dir);
        t_work r;
        r = w;
        if (dir != r.st.op) begin
            if (dir == OP_IDLE) begin
                r.drive = TRIG_STOP;
            end else begin
                r.st.disengaged = 1'b0;
                r.st.last_dir   = dir;
                r.drive         = (dir == OP_OPENING) ? TRIG_OPEN : TRIG_CLOSE;
            end
            r.st.op        = dir;
            r.st.run_timer = '0;
        end
        return r;
    endfunction

    // Begin the disengage pulse, or go idle once disengaged
    function automatic t_work f_go_idle(t_work w);
        t_work r;
        r = w;
        if (!r.st.disengaged) begin
            r.st.disengaging = 1'b1;
            r.st.dis_timer   = '0;
            if (r.st.op == OP_OPENING) begin
                r.drive = TRIG_CLOSE;
            end else if (r.st.op == OP_CLOSING) begin
                r.drive = TRIG_OPEN;
            end
        end else begin
            r = f_begin(r, OP_IDLE);
            r.pub = 1'b1;
        end
        return r;
    endfunction

    function automatic logic f_reached(t_work w, logic [9:0] pos);
        logic hit;
        case (w.st.op)
            OP_OPENING: hit = (pos >= w.st.target);
            OP_CLOSING: hit = (pos <= w.st.target);
            default:    hit = 1'b1;
        endcase
        return hit;
    endfunction

    // Work through one request
    always_comb begin
        t_work      w;
        logic [9:0] pos;
        logic [9:0] req;
        logic [9:0] diff;
        logic       report_due;

        pos  = (i_req.sensor_position > POS_OPEN) ? POS_OPEN : i_req.sensor_position;
        req  = (i_req.requested_position > POS_OPEN) ? POS_OPEN
                                                     : i_req.requested_position;
        diff = (req > pos) ? (req - pos) : (pos - req);
        report_due = (i_state.pub_timer >= i_cfg.publish_period_ms);

        w.st    = i_state;
        w.drive = TRIG_NONE;
        w.pub   = 1'b0;

        case (i_req.action)
            ACT_TICK: begin
                // Advance the saturating timers
                if (w.st.run_timer != '1) begin
                    w.st.run_timer = w.st.run_timer + 32'd1;
                end
                if (w.st.dis_timer != '1) begin
                    w.st.dis_timer = w.st.dis_timer + 32'd1;
                end
                if (w.st.op == OP_IDLE) begin
                    if (w.st.pub_timer != '1) begin
                        w.st.pub_timer = w.st.pub_timer + 16'd1;
                    end
                end else begin
                    w.st.position = pos;
                    if (w.st.run_timer > i_cfg.max_run_ms) begin
                        w = f_go_idle(w);
                    end
                    if (w.st.disengaging) begin
                        if (w.st.dis_timer > i_cfg.disengage_ms) begin
                            w.st.disengaged  = 1'b1;
                            w.st.disengaging = 1'b0;
                            w = f_go_idle(w);
                        end
                    end else if (f_reached(w, pos)) begin
                        w.st.disengaged = 1'b0;
                        w = f_go_idle(w);
                    end
                    // Request a periodic report
                    if (report_due) begin
                        w.pub          = 1'b1;
                        w.st.pub_timer = '0;
                    end else if (w.st.pub_timer != '1) begin
                        w.st.pub_timer = w.st.pub_timer + 16'd1;
                    end
                end
            end
            ACT_STOP: begin
                w = f_go_idle(w);
                w.st.position = pos;
            end
            ACT_TOGGLE: begin
                w.st.position = pos;
                if (w.st.op != OP_IDLE) begin
                    w = f_begin(w, OP_IDLE);
                    w.pub = 1'b1;
                end else if (pos == POS_CLOSED || w.st.last_dir == OP_CLOSING) begin
                    w.st.target = POS_OPEN;
                    w = f_begin(w, OP_OPENING);
                end else begin
                    w.st.target = POS_CLOSED;
                    w = f_begin(w, OP_CLOSING);
                end
            end
            default: begin
                // Go to target unless already within tolerance
                w.st.position = pos;
                if (diff >= POS_TOLERANCE) begin
                    w.st.target = req;
                    w = f_begin(w, (req < pos) ? OP_CLOSING : OP_OPENING);
                end
            end
        endcase

        o_state                    = w.st;
        o_result.drive_command     = w.drive;
        o_result.operation         = w.st.op;
        o_result.reported_position = w.st.position;
        o_result.publish           = w.pub;
    end

endmodule

// ----- rtl/core/cds_out_stage.sv -----
// Result register stage of the cover drive sequencer.
module cds_out_stage
    import cds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cds_out i_result,
    input  logic     i_out_stall,
    output logic     o_advance,
    output logic     o_out_valid,
    output t_cds_out o_out
);

    logic     r_valid;
    t_cds_out r_out;

    // Advance unless a result is waiting and stalled
    assign o_advance = !(r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_out <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/core/cover_drive_sequencer_core.sv -----
// Top level of the cover drive sequencer: state, configuration and stages.
//
//   channel   direction  handshake            payload
//   in        input      i_in_valid/o_in_stall  t_cds_in  (action, positions)
//   out       output     o_out_valid/i_out_stall t_cds_out (trigger, op, pos, pub)
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A result is offered once the result register holds it: the request
// sits in the input register while the step logic works on it, and the
// result register loads it when the output does not stall.
// A new request is accepted every cycle unless the result stalls; the step
// logic updates the state in the same cycle as it loads the result register.
// A stalled result holds both stages; the input stalls only then.
// Synchronous reset sets state and configuration to their reset values
// and clears the valid flags; the configuration port is always ready.
module cover_drive_sequencer_core
    import cds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_cds_in     i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_cds_out    o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cds_cfg   r_cfg;
    t_cds_state r_state;
    t_cds_state n_state;
    t_cds_in    req;
    t_cds_out   result;
    logic       req_valid;
    logic       advance;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_run_ms        <= MAX_RUN_RESET;
            r_cfg.disengage_ms      <= DISENGAGE_RESET;
            r_cfg.publish_period_ms <= PUB_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_RUN:    r_cfg.max_run_ms        <= i_cfg_data;
                CFG_DISENGAGE:  r_cfg.disengage_ms      <= i_cfg_data;
                CFG_PUB_PERIOD: r_cfg.publish_period_ms <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    cds_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_advance  (advance),
        .o_valid    (req_valid),
        .o_req      (req)
    );

    cds_step u_step (
        .i_req    (req),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (result)
    );

    // Commit the state when a request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.op          <= OP_IDLE;
            r_state.last_dir    <= OP_IDLE;
            r_state.target      <= POS_CLOSED;
            r_state.position    <= POS_RESET;
            r_state.disengaging <= 1'b0;
            r_state.disengaged  <= 1'b0;
            r_state.run_timer   <= '0;
            r_state.dis_timer   <= '0;
            r_state.pub_timer   <= '0;
        end else if (req_valid && advance) begin
            r_state <= n_state;
        end
    end

    cds_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (req_valid),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/core/cds_checker.sv -----
// Port-level checker of the cover drive sequencer and its bind.
`include "cover_drive_sequencer_core_assert.svh"

module cds_checker
    import cds_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_cds_out    o_out
);

    // A stalled result keeps its payload
    `CDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out),
        "stalled result changed")

    // Reset empties the result register
    `CDS_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

    // A stop trigger leaves the cover idle with a report
    `CDS_ASSERT_NOW(a_stop_idle, i_clk, i_rst_n,
        o_out_valid && o_out.drive_command == TRIG_STOP,
        o_out.operation == OP_IDLE && o_out.publish,
        "stop without idle report")

    // The input stalls only behind a stalled result
    `CDS_ASSERT_NOW(a_in_stall, i_clk, i_rst_n,
        o_in_stall,
        o_out_valid && i_out_stall,
        "input stalled without cause")

    // Open and close triggers fire only while moving
    `CDS_ASSERT_NOW(a_drive_moving, i_clk, i_rst_n,
        o_out_valid && (o_out.drive_command == TRIG_OPEN || o_out.drive_command == TRIG_CLOSE),
        o_out.operation != OP_IDLE && o_out.reported_position <= POS_OPEN,
        "drive trigger while idle")

endmodule

bind cover_drive_sequencer_core cds_checker u_cds_checker (.*);
